[rtl/blat_pkg.sv]
package blat_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned LEASE_W         = 8;
  localparam int unsigned LIVE_W          = 5;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned OUT_TDATA_W     = 72;

  localparam logic [LEASE_W-1:0] LEASE_RESET = 8'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP   = 3'd0,
    KIND_INSERTED = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_UNMAP    = 3'd3,
    KIND_DONE     = 3'd4
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic walk;
    logic apply;
    logic emit_load;
    logic final_load;
  } blat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_last;
    logic freed_any;
    logic out_free;
  } blat_sts_t;

  function automatic int unsigned idx_width(int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[rtl/blat_ram.sv]
module blat_ram import blat_pkg::*; #(
  parameter int unsigned WIDTH = KEY_W,
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [idx_width(DEPTH)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]             wr_data,
  input  logic [idx_width(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/blat_ctrl.sv]
module blat_ctrl import blat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  blat_sts_t sts,
  output blat_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_WALK   = 7'b0000010,
    ST_DRAIN  = 7'b0000100,
    ST_APPLY  = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_UNMAP  = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        state_nxt = sts.freed_any ? ST_UNMAP : ST_RESULT;
      end
      ST_UNMAP: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.final_load = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/blat_dp.sv]
module blat_dp import blat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  blat_cmd_t               cmd,
  output blat_sts_t               sts,
  input  logic                    cfg_wr_en,
  input  logic [LEASE_W-1:0]      cfg_wr_data,
  input  logic [KEY_W-1:0]        in_tdata,
  input  logic [OP_W-1:0]         in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic [KIND_W-1:0]       out_tuser,
  output logic                    out_tlast
);

  localparam int unsigned IDX_W = idx_width(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [LEASE_W-1:0]                   lease_reload_r;
  logic [TABLE_DEPTH-1:0]               slot_valid_r;
  logic [TABLE_DEPTH-1:0]               slot_flag_r;
  logic [TABLE_DEPTH-1:0][LEASE_W-1:0]  slot_lease_r;
  logic [TABLE_DEPTH-1:0]               freed_r;
  logic [CNT_W-1:0]                     live_r;
  logic [IDX_W-1:0]                     walk_cnt_r;
  logic                                 pipe_v_r;
  logic                                 match_r;
  logic                                 free_found_r;
  logic                                 out_valid_r;

  op_t                                  op_r;
  logic [KEY_W-1:0]                     key_r;
  logic [IDX_W-1:0]                     pipe_idx_r;
  logic [IDX_W-1:0]                     free_idx_r;
  kind_t                                out_kind_r;
  logic [KEY_W-1:0]                     out_key_r;
  logic                                 out_hit_r;
  logic [LIVE_W-1:0]                    out_live_r;
  logic                                 out_last_r;

  logic [KEY_W-1:0]   ram_rdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [IDX_W-1:0]   freed_idx;
  logic               cur_valid;
  logic               cmp_hit;
  logic               flag_set;
  logic [LEASE_W-1:0] cur_lease;
  logic [LEASE_W-1:0] lease_dec;
  logic               do_alloc;
  logic               out_free;
  kind_t              final_kind;
  logic               final_hit;

  // lowest freed slot goes out first
  always_comb begin
    freed_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (freed_r[i]) begin
        freed_idx = IDX_W'(i);
      end
    end
  end

  assign ram_raddr = cmd.walk ? walk_cnt_r : freed_idx;
  assign do_alloc  = (op_r == OP_INSERT) && !match_r && free_found_r;

  blat_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (cmd.apply && do_alloc),
    .wr_addr (free_idx_r),
    .wr_data (key_r),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // compare stage, one slot per cycle
  assign cur_valid = slot_valid_r[pipe_idx_r];
  assign cur_lease = slot_lease_r[pipe_idx_r];
  assign cmp_hit   = cur_valid && (ram_rdata == key_r);
  assign flag_set  = slot_flag_r[pipe_idx_r] || cmp_hit;
  assign lease_dec = (cur_lease == '0) ? '0 : cur_lease - LEASE_W'(1);

  always_comb begin
    final_kind = KIND_DONE;
    final_hit  = 1'b0;
    case (op_r)
      OP_LOOKUP: begin
        final_kind = KIND_LOOKUP;
        final_hit  = match_r;
      end
      OP_INSERT: begin
        final_kind = (match_r || free_found_r) ? KIND_INSERTED : KIND_FULL;
      end
      OP_RELEASE, OP_CLEAR: begin
        final_kind = KIND_DONE;
      end
      default: begin
        final_kind = KIND_DONE;
      end
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_reload_r <= LEASE_RESET;
      slot_valid_r   <= '0;
      slot_flag_r    <= '0;
      slot_lease_r   <= '0;
      freed_r        <= '0;
      live_r         <= '0;
      walk_cnt_r     <= '0;
      pipe_v_r       <= 1'b0;
      match_r        <= 1'b0;
      free_found_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lease_reload_r <= cfg_wr_data;
      end
      if (cmd.capture) begin
        walk_cnt_r   <= '0;
        match_r      <= 1'b0;
        free_found_r <= 1'b0;
        freed_r      <= '0;
      end
      if (cmd.walk) begin
        walk_cnt_r <= walk_cnt_r + IDX_W'(1);
      end
      pipe_v_r <= cmd.walk;
      if (pipe_v_r) begin
        case (op_r)
          OP_LOOKUP: begin
            if (cmp_hit) begin
              slot_lease_r[pipe_idx_r] <= lease_reload_r;
              match_r                  <= 1'b1;
            end
          end
          OP_INSERT: begin
            if (cmp_hit) begin
              slot_lease_r[pipe_idx_r] <= lease_reload_r;
              match_r                  <= 1'b1;
            end
            if (!cur_valid && !free_found_r) begin
              free_found_r <= 1'b1;
            end
          end
          OP_RELEASE: begin
            if (cur_valid && flag_set) begin
              if (lease_dec == '0) begin
                slot_valid_r[pipe_idx_r] <= 1'b0;
                slot_flag_r[pipe_idx_r]  <= 1'b0;
                freed_r[pipe_idx_r]      <= 1'b1;
                live_r                   <= live_r - CNT_W'(1);
              end else begin
                slot_lease_r[pipe_idx_r] <= lease_dec;
                slot_flag_r[pipe_idx_r]  <= 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            if (cmp_hit) begin
              slot_flag_r[pipe_idx_r] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.apply && do_alloc) begin
        slot_valid_r[free_idx_r] <= 1'b1;
        slot_flag_r[free_idx_r]  <= 1'b0;
        slot_lease_r[free_idx_r] <= lease_reload_r;
        live_r                   <= live_r + CNT_W'(1);
      end
      if (cmd.emit_load) begin
        freed_r[freed_idx] <= 1'b0;
      end
      if (cmd.emit_load || cmd.final_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_tuser);
      key_r <= in_tdata;
    end
    pipe_idx_r <= walk_cnt_r;
    if (pipe_v_r && (op_r == OP_INSERT) && !cur_valid && !free_found_r) begin
      free_idx_r <= pipe_idx_r;
    end
    if (cmd.emit_load) begin
      out_kind_r <= KIND_UNMAP;
      out_key_r  <= ram_rdata;
      out_hit_r  <= 1'b0;
      out_live_r <= LIVE_W'(live_r);
      out_last_r <= 1'b0;
    end else if (cmd.final_load) begin
      out_kind_r <= final_kind;
      out_key_r  <= key_r;
      out_hit_r  <= final_hit;
      out_live_r <= LIVE_W'(live_r);
      out_last_r <= 1'b1;
    end
  end

  assign sts.walk_last = (walk_cnt_r == IDX_W'(TABLE_DEPTH - 1));
  assign sts.freed_any = |freed_r;
  assign sts.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_live_r, out_hit_r, out_key_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/buffer_lease_aging_table.sv]
// channel  | dir | handshake           | payload
// in_      | in  | in_tvalid/in_tready   | tdata: buf_key; tuser: opcode
// out_     | out | out_tvalid/out_tready | tdata: result_key, hit, live_entries;
//          |     |                       | tuser: result_kind; tlast: last
// cfg_     | in  | cfg_wr_en             | cfg_wr_data: lease_reload
//
// one item at a time: every item walks all TABLE_DEPTH slots through the key ram,
// one slot per cycle, then emits one unmap result per freed slot and a final result
// the single key ram read port serves both the slot walk and the unmap key reads
// rst_n is synchronous: all slots empty, lease_reload back to 8, no clearing pass
// a held result stalls emission; the next item is taken while the last result waits
module buffer_lease_aging_table import blat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // config write, no read-back
  input  logic                   cfg_wr_en,
  input  logic [LEASE_W-1:0]     cfg_wr_data,   // lease_reload
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KEY_W-1:0]       in_tdata,      // [63:0] buf_key
  input  logic [OP_W-1:0]        in_tuser,      // [1:0] opcode
  // result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,     // [63:0] result_key, [64] hit,
                                                // [69:65] live_entries, zero pad
  output logic [KIND_W-1:0]      out_tuser,     // [2:0] result_kind
  output logic                   out_tlast      // last result of the item
);

  blat_cmd_t cmd;
  blat_sts_t sts;

  // sequencer: accept, slot walk, apply, unmap emission, final result
  blat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot table, key ram, compare stage and output register
  blat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // at most one sequencer command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.walk, cmd.apply, cmd.emit_load, cmd.final_load}))
    else $error("more than one sequencer command in a cycle");

  // an accepted item keeps the block busy for at least the walk
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again right after an accept");

  // unmap results never close an item
  a_unmap_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_UNMAP)) |-> !out_tlast)
    else $error("unmap result marked as last");

  // results are only loaded when the output register is free
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load || cmd.final_load) |-> (!out_tvalid || out_tready))
    else $error("result loaded over a held result");

endmodule

[sim/tb_buffer_lease_aging_table.sv]
`timescale 1ns / 100ps

module tb_buffer_lease_aging_table import blat_pkg::*; ();

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
  localparam int unsigned SETTLE       = DEPTH + 16;   // walk of all slots plus margin
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned PHASE_ITEMS  = 28;
  localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_FIVES = 64'h5555_5555_5555_5555;
  localparam logic [KEY_W-1:0] KEY_TENS  = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [KEY_W-1:0] KEY_TOP   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    kind_t              kind;
    logic [KEY_W-1:0]   key;
    logic               hit;
    logic [LIVE_W-1:0]  live;
    logic               last;
  } lease_result_t;

  // one row of the directed stimulus: either a lease write or a run of items
  typedef struct {
    bit                 is_cfg;
    logic [LEASE_W-1:0] cfg_val;
    op_t                op;
    logic [KEY_W-1:0]   key;
    int                 reps;
    bit                 typed;
    lease_result_t      want;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [LEASE_W-1:0]     cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [KEY_W-1:0]       in_tdata    = '0;   // [63:0] buf_key
  logic [OP_W-1:0]        in_tuser    = '0;   // [1:0] opcode
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // [63:0] result_key, [64] hit, [69:65] live
  logic [KIND_W-1:0]      out_tuser;          // [2:0] result_kind
  logic                   out_tlast;

  buffer_lease_aging_table #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // lease table mirror
  logic [KEY_W-1:0]   tbl_key   [DEPTH];
  bit                 tbl_valid [DEPTH];
  logic [LEASE_W-1:0] tbl_lease [DEPTH];
  bit                 tbl_flag  [DEPTH];
  logic [LEASE_W-1:0] reload_val;

  lease_result_t expected_results[$];
  stim_row_t     stim_rows[$];
  logic [KEY_W-1:0] key_pool[POOL_SIZE];

  int error_count = 0;
  int cycle_count = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic lease_result_t make_result(kind_t kind, logic [KEY_W-1:0] key,
                                                logic hit, logic last);
    lease_result_t r;
    r.kind = kind;
    r.key  = key;
    r.hit  = hit;
    r.live = '0;
    r.last = last;
    return r;
  endfunction

  // applies one item to the mirror; record=0 only updates the table
  function automatic void lease_table_apply(op_t op, logic [KEY_W-1:0] key, bit record);
    lease_result_t staged[$];
    int found;
    int free_slot;
    int live;
    found = -1;
    free_slot = -1;
    live = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (found < 0 && tbl_valid[i] && tbl_key[i] == key) found = i;
      if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
    end
    case (op)
      OP_LOOKUP: begin
        if (found >= 0) tbl_lease[found] = reload_val;
        staged.push_back(make_result(KIND_LOOKUP, key, found >= 0, 1'b1));
      end
      OP_INSERT: begin
        if (found >= 0) begin
          // key already mapped: reload only, flag kept
          tbl_lease[found] = reload_val;
          staged.push_back(make_result(KIND_INSERTED, key, 1'b0, 1'b1));
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_key[free_slot]   = key;
          tbl_lease[free_slot] = reload_val;
          tbl_flag[free_slot]  = 1'b0;
          staged.push_back(make_result(KIND_INSERTED, key, 1'b0, 1'b1));
        end else begin
          staged.push_back(make_result(KIND_FULL, key, 1'b0, 1'b1));
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_key[i] == key) tbl_flag[i] = 1'b1;
            if (tbl_flag[i]) begin
              if (tbl_lease[i] != '0) tbl_lease[i] = tbl_lease[i] - 1'b1;
              if (tbl_lease[i] == '0) begin
                tbl_valid[i] = 1'b0;
                tbl_flag[i]  = 1'b0;
                staged.push_back(make_result(KIND_UNMAP, tbl_key[i], 1'b0, 1'b0));
              end
            end
          end
        end
        staged.push_back(make_result(KIND_DONE, key, 1'b0, 1'b1));
      end
      default: begin
        for (int i = 0; i < DEPTH; i++)
          if (tbl_valid[i] && tbl_key[i] == key) tbl_flag[i] = 1'b0;
        staged.push_back(make_result(KIND_DONE, key, 1'b0, 1'b1));
      end
    endcase
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i]) live++;
    if (record) begin
      foreach (staged[j]) begin
        staged[j].live = live[LIVE_W-1:0];
        expected_results.push_back(staged[j]);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    $display("cycle %0d: %s mismatch, got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // stalls on both sides; calm stretches switch all idling off for a while
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int tx_calm_left = 0;
  int rx_calm_left = 0;
  int rx_stall_left = 0;

  always @(posedge clk) begin
    if (tx_calm_left == 0) begin
      tx_calm      <= ($urandom_range(0, 3) == 0);
      tx_calm_left <= $urandom_range(20, 200);
    end else begin
      tx_calm_left <= tx_calm_left - 1;
    end
    if (rx_calm_left == 0) begin
      rx_calm      <= ($urandom_range(0, 3) == 0);
      rx_calm_left <= $urandom_range(20, 200);
    end else begin
      rx_calm_left <= rx_calm_left - 1;
    end
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_tready    <= 1'b0;
    end else begin : pick_stall
      int gap;
      gap = pick_gap(rx_calm);
      if (gap == 0) begin
        out_tready <= 1'b1;
      end else begin
        rx_stall_left <= gap - 1;
        out_tready    <= 1'b0;
      end
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    lease_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result key", out_tdata[KEY_W-1:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser != want.kind)
          report_mismatch("result_kind", KEY_W'(out_tuser), KEY_W'(want.kind));
        if (out_tdata[KEY_W-1:0] != want.key)
          report_mismatch("result_key", out_tdata[KEY_W-1:0], want.key);
        if (out_tdata[KEY_W] != want.hit)
          report_mismatch("hit", KEY_W'(out_tdata[KEY_W]), KEY_W'(want.hit));
        if (out_tdata[KEY_W+LIVE_W:KEY_W+1] != want.live)
          report_mismatch("live_entries", KEY_W'(out_tdata[KEY_W+LIVE_W:KEY_W+1]),
                          KEY_W'(want.live));
        if (out_tdata[OUT_TDATA_W-1:KEY_W+LIVE_W+1] != '0)
          report_mismatch("tdata pad", KEY_W'(out_tdata[OUT_TDATA_W-1:KEY_W+LIVE_W+1]), '0);
        if (out_tlast != want.last)
          report_mismatch("last", KEY_W'(out_tlast), KEY_W'(want.last));
      end
    end
  end

  // sends one item; called right after a rising edge, returns at its acceptance edge
  task automatic drive_item(input op_t op, input logic [KEY_W-1:0] key, input bit use_typed,
                            input lease_result_t typed_res);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    lease_table_apply(op, key, !use_typed);
    if (use_typed) expected_results.push_back(typed_res);
  endtask

  // lease writes only while the table is idle
  task automatic set_lease(input logic [LEASE_W-1:0] val);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    reload_val = val;
  endtask

  task automatic add_item(input op_t op, input logic [KEY_W-1:0] key, input kind_t kind,
                          input logic hit, input int live);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = '0;
    row.op      = op;
    row.key     = key;
    row.reps    = 1;
    row.typed   = 1'b1;
    row.want    = make_result(kind, key, hit, 1'b1);
    row.want.live = live[LIVE_W-1:0];
    stim_rows.push_back(row);
  endtask

  task automatic add_untyped(input op_t op, input logic [KEY_W-1:0] key, input int reps);
    stim_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = '0;
    row.op      = op;
    row.key     = key;
    row.reps    = reps;
    row.typed   = 1'b0;
    row.want    = '0;
    stim_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [LEASE_W-1:0] val);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_val = val;
    row.op      = OP_LOOKUP;
    row.key     = '0;
    row.reps    = 0;
    row.typed   = 1'b0;
    row.want    = '0;
    stim_rows.push_back(row);
  endtask

  // one random item, or a short lease run: insert, lookup, then ticks until freed
  task automatic random_burst(output int sent);
    logic [KEY_W-1:0] key;
    lease_result_t none;
    int r;
    none = '0;
    sent = 0;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
    else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 20 && reload_val <= 4) begin
      drive_item(OP_INSERT, key, 1'b0, none);
      drive_item(OP_LOOKUP, key, 1'b0, none);
      sent = 2;
      for (int i = 0; i <= reload_val; i++) begin
        drive_item(OP_RELEASE, key, 1'b0, none);
        sent++;
      end
    end else if (r < 48) begin
      drive_item(OP_INSERT, key, 1'b0, none);
      sent = 1;
    end else if (r < 68) begin
      drive_item(OP_LOOKUP, key, 1'b0, none);
      sent = 1;
    end else if (r < 88) begin
      drive_item(OP_RELEASE, key, 1'b0, none);
      sent = 1;
    end else begin
      drive_item(OP_CLEAR, key, 1'b0, none);
      sent = 1;
    end
  endtask

  initial begin : stimulus
    logic [LEASE_W-1:0] phase_lease[5];
    int sent;
    int burst;
    reload_val = LEASE_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_key[i]   = '0;
      tbl_valid[i] = 1'b0;
      tbl_lease[i] = '0;
      tbl_flag[i]  = 1'b0;
    end

    // directed part, lease at its reset value until the first write
    add_item(OP_LOOKUP, '0, KIND_LOOKUP, 1'b0, 0);          // empty table
    add_item(OP_RELEASE, KEY_ONES, KIND_DONE, 1'b0, 0);
    add_item(OP_INSERT, '0, KIND_INSERTED, 1'b0, 1);
    add_item(OP_INSERT, KEY_ONES, KIND_INSERTED, 1'b0, 2);
    add_item(OP_INSERT, '0, KIND_INSERTED, 1'b0, 2);        // key already mapped
    add_item(OP_LOOKUP, KEY_ONES, KIND_LOOKUP, 1'b1, 2);
    add_item(OP_INSERT, KEY_FIVES, KIND_INSERTED, 1'b0, 3);
    add_item(OP_INSERT, KEY_TENS, KIND_INSERTED, 1'b0, 4);
    add_item(OP_RELEASE, '0, KIND_DONE, 1'b0, 4);           // flags slot 0, lease 8 to 7
    add_item(OP_CLEAR, '0, KIND_DONE, 1'b0, 4);
    add_untyped(OP_INSERT, 64'h100, 12);                    // fills the table
    add_item(OP_INSERT, KEY_TOP, KIND_FULL, 1'b0, 16);      // no free slot
    add_cfg(8'd1);
    add_item(OP_LOOKUP, KEY_TENS, KIND_LOOKUP, 1'b1, 16);   // reload to 1
    add_untyped(OP_RELEASE, KEY_TENS, 1);                   // unmap, then done
    add_item(OP_INSERT, KEY_TOP, KIND_INSERTED, 1'b0, 16);  // takes the lowest free slot
    add_cfg(8'd255);
    add_item(OP_LOOKUP, '0, KIND_LOOKUP, 1'b1, 16);
    add_item(OP_RELEASE, '0, KIND_DONE, 1'b0, 16);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[n]) begin
      if (stim_rows[n].is_cfg) begin
        set_lease(stim_rows[n].cfg_val);
      end else begin
        for (int j = 0; j < stim_rows[n].reps; j++)
          drive_item(stim_rows[n].op, stim_rows[n].key + j, stim_rows[n].typed,
                     stim_rows[n].want);
      end
    end

    // random part: short leases so entries age out and slots churn
    phase_lease[0] = 8'd2;
    phase_lease[1] = 8'd1;
    phase_lease[2] = 8'd4;
    phase_lease[3] = LEASE_W'($urandom_range(5, 255));
    phase_lease[4] = 8'd3;
    for (int p = 0; p < 5; p++) begin
      set_lease(phase_lease[p]);
      for (int i = 0; i < POOL_SIZE; i++)
        if (p == 0 || $urandom_range(0, 2) == 0) key_pool[i] = {$urandom, $urandom};
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_burst(burst);
        sent += burst;
      end
    end

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
